>>> rtl/lifsoma_pkg.sv
// shared types, constants and helpers for the lif neuron soma update block
package lifsoma_pkg;

    localparam int POTENTIAL_WIDTH = 20;
    localparam int EXT_WIDTH = ((POTENTIAL_WIDTH > 19) ? POTENTIAL_WIDTH : 19) + 3;

    localparam int SYN_WIDTH = 18;
    localparam int OUT_POT_WIDTH = 20;
    localparam int STATUS_WIDTH = 2;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 19;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LEAK_VALUE       = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_POS_THRESHOLD    = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_NEG_THRESHOLD    = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_THRESHOLD_MASK   = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RESET_POTENTIAL  = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MODE_BITS        = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LEAK_RANDOM      = 3'd6;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_THRESHOLD_RANDOM = 3'd7;

    localparam logic [1:0] RST_LOAD = 2'd0;
    localparam logic [1:0] RST_SUB  = 2'd1;
    localparam logic [1:0] RST_KEEP = 2'd2;
    localparam logic [1:0] RST_ZERO = 2'd3;

    localparam logic [STATUS_WIDTH-1:0] ST_IDLE = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_NEG  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FIRE = 2'd2;

    localparam logic signed [EXT_WIDTH-1:0] POT_MAX =
        EXT_WIDTH'((64'sd1 <<< (POTENTIAL_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EXT_WIDTH-1:0] POT_MIN = -POT_MAX - EXT_WIDTH'(1);

    typedef logic signed [EXT_WIDTH-1:0] ext_t;

    typedef struct packed {
        logic signed [8:0]  leak_value;
        logic [17:0]        pos_threshold;
        logic [17:0]        neg_threshold;
        logic [17:0]        threshold_mask;
        logic signed [18:0] reset_potential;
        logic [4:0]         mode_bits;
        logic [7:0]         leak_random;
        logic [17:0]        threshold_random;
    } lifsoma_cfg_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]           status;
        logic signed [POTENTIAL_WIDTH-1:0] potential;
    } lifsoma_res_t;

    function automatic ext_t sat_pot(input ext_t v);
        ext_t r;
        if (v > POT_MAX) begin
            r = POT_MAX;
        end else if (v < POT_MIN) begin
            r = POT_MIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/lifsoma_core.sv
// combinational membrane update: integrate, leak, threshold checks and reset
module lifsoma_core (
    input  lifsoma_pkg::lifsoma_cfg_t                 cfg,
    input  logic signed [lifsoma_pkg::POTENTIAL_WIDTH-1:0] potential,
    input  logic signed [lifsoma_pkg::SYN_WIDTH-1:0]       synaptic_sum,
    output lifsoma_pkg::lifsoma_res_t                 res
);
    import lifsoma_pkg::*;

    always_comb begin
        ext_t v;
        ext_t lambda;
        ext_t mag;
        ext_t term;
        ext_t n;
        ext_t alpha_n;
        ext_t beta;
        ext_t beta_n;
        ext_t r;
        logic [1:0] rmode;
        logic [STATUS_WIDTH-1:0] status;

        lambda  = EXT_WIDTH'(cfg.leak_value);
        r       = EXT_WIDTH'(cfg.reset_potential);
        n       = ext_t'({{(EXT_WIDTH-18){1'b0}}, cfg.threshold_random & cfg.threshold_mask});
        beta    = ext_t'({{(EXT_WIDTH-18){1'b0}}, cfg.neg_threshold});
        beta_n  = beta + n;
        alpha_n = ext_t'({{(EXT_WIDTH-18){1'b0}}, cfg.pos_threshold}) + n;
        rmode   = cfg.mode_bits[4:3];
        status  = ST_IDLE;

        // integrate
        v = sat_pot(EXT_WIDTH'(potential) + EXT_WIDTH'(synaptic_sum));

        // leak
        if (cfg.mode_bits[1]) begin
            mag = (lambda < 0) ? -lambda : lambda;
            if (mag >= ext_t'({{(EXT_WIDTH-8){1'b0}}, cfg.leak_random})) begin
                term = (lambda < 0) ? -ext_t'(1) : ((lambda > 0) ? ext_t'(1) : ext_t'(0));
            end else begin
                term = '0;
            end
        end else begin
            mag  = '0;
            term = lambda;
        end
        if (cfg.mode_bits[0]) begin
            term = (v < 0) ? -term : ((v > 0) ? term : ext_t'(0));
        end
        v = sat_pot(v + term);

        // negative threshold
        if (cfg.mode_bits[2]) begin
            if (v < -beta) begin
                status = ST_NEG;
                v = sat_pot(-beta);
            end
        end else if (v < -beta_n) begin
            status = ST_NEG;
            case (rmode)
                RST_LOAD: v = sat_pot(-r);
                RST_SUB:  v = sat_pot(v + beta_n);
                RST_KEEP: v = v;
                default:  v = '0;
            endcase
        end

        // positive threshold, firing wins
        if (v >= alpha_n) begin
            status = ST_FIRE;
            case (rmode)
                RST_LOAD: v = sat_pot(r);
                RST_SUB:  v = sat_pot(v - alpha_n);
                RST_KEEP: v = v;
                default:  v = '0;
            endcase
        end

        res.status    = status;
        res.potential = v[POTENTIAL_WIDTH-1:0];
    end

endmodule

>>> rtl/lif_neuron_soma_update.sv
// top level of the lif neuron soma update block
//
// usage: each transaction on the s_ channel is one tick carrying the signed
// synaptic sum. the block adds it to the membrane potential, applies leak,
// checks both thresholds and returns one transaction on the m_ channel with
// the neuron status in m_tuser and the updated potential in m_tdata.
// a tick accepted at one edge shows up on m_ right after it. throughput is
// one tick per cycle while m_tready is high; the membrane update, a chain
// of adds, compares and saturation, is combinational and sits between the
// potential register and the result register.
// when the receiver stalls, the result register holds its transaction and
// s_tready drops until that result is taken; with m_tready high the block
// takes a tick every cycle.
// registers are written through cfg_wr_en/cfg_addr/cfg_wdata, one per cycle;
// the user must write them only while no tick is in flight (not enforced).
// reset (aresetn low, synchronous) clears the potential to zero, empties the
// result register and loads the register defaults: pos_threshold 1, others 0.
module lif_neuron_soma_update (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [23:0]                            s_tdata,   // synaptic_sum[17:0]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [23:0]                            m_tdata,   // potential_out[19:0]
    output logic [1:0]                             m_tuser,   // soma_status[1:0]
    input  logic                                   cfg_wr_en,
    input  logic [lifsoma_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [lifsoma_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);
    import lifsoma_pkg::*;

    lifsoma_cfg_t                     cfg_reg;
    logic signed [POTENTIAL_WIDTH-1:0] pot_reg;
    logic                             out_valid_reg;
    logic [STATUS_WIDTH-1:0]          out_status_reg;
    logic signed [OUT_POT_WIDTH-1:0]  out_pot_reg;
    lifsoma_res_t                     res_next;
    logic                             in_fire;
    ext_t                             pot_ext;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    lifsoma_core u_core (
        .cfg          (cfg_reg),
        .potential    (pot_reg),
        .synaptic_sum (s_tdata[SYN_WIDTH-1:0]),
        .res          (res_next)
    );

    assign pot_ext = EXT_WIDTH'(res_next.potential);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leak_value       <= '0;
            cfg_reg.pos_threshold    <= 18'd1;
            cfg_reg.neg_threshold    <= '0;
            cfg_reg.threshold_mask   <= '0;
            cfg_reg.reset_potential  <= '0;
            cfg_reg.mode_bits        <= '0;
            cfg_reg.leak_random      <= '0;
            cfg_reg.threshold_random <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LEAK_VALUE:       cfg_reg.leak_value       <= cfg_wdata[8:0];
                CFG_POS_THRESHOLD:    cfg_reg.pos_threshold    <= cfg_wdata[17:0];
                CFG_NEG_THRESHOLD:    cfg_reg.neg_threshold    <= cfg_wdata[17:0];
                CFG_THRESHOLD_MASK:   cfg_reg.threshold_mask   <= cfg_wdata[17:0];
                CFG_RESET_POTENTIAL:  cfg_reg.reset_potential  <= cfg_wdata[18:0];
                CFG_MODE_BITS:        cfg_reg.mode_bits        <= cfg_wdata[4:0];
                CFG_LEAK_RANDOM:      cfg_reg.leak_random      <= cfg_wdata[7:0];
                CFG_THRESHOLD_RANDOM: cfg_reg.threshold_random <= cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                pot_reg       <= res_next.potential;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_status_reg <= res_next.status;
            out_pot_reg    <= pot_ext[OUT_POT_WIDTH-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_pot_reg};

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_IDLE || m_tuser == ST_NEG || m_tuser == ST_FIRE))
        else $error("invalid neuron status code");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid)
        else $error("accepted tick produced no result");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !s_tvalid) |=> !m_tvalid)
        else $error("result repeated after being taken");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

>>> verif/lif_soma_checker.sv
// checker for the lif neuron soma update block: tracks registers, predicts and compares ticks
module lif_soma_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [23:0]                            s_tdata,    // synaptic_sum[17:0]
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [23:0]                            m_tdata,    // potential_out[19:0]
    input  logic [1:0]                             m_tuser,    // soma_status[1:0]
    input  logic                                   cfg_wr_en,
    input  logic [lifsoma_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [lifsoma_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    output int                                     outstanding,
    output int                                     mismatches,
    output int                                     checked,
    output int                                     spikes,
    output int                                     neg_resets
);
    import lifsoma_pkg::*;

    typedef struct {
        logic [STATUS_WIDTH-1:0]         status;
        logic signed [OUT_POT_WIDTH-1:0] potential;
    } soma_result_t;

    lifsoma_cfg_t                      regs;
    logic signed [POTENTIAL_WIDTH-1:0] membrane;
    soma_result_t                      expected_results[$];
    int                                n_bad;
    int                                n_seen;
    int                                n_fire;
    int                                n_neg;

    function automatic longint clamp_membrane(input longint v);
        longint hi;
        hi = (longint'(1) <<< (POTENTIAL_WIDTH - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint sign_of(input longint v);
        return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
    endfunction

    function automatic soma_result_t soma_tick(input logic signed [SYN_WIDTH-1:0] syn);
        longint       v;
        longint       leak;
        longint       term;
        longint       alpha;
        longint       beta;
        longint       n;
        longint       rlevel;
        logic [1:0]   rmode;
        soma_result_t r;
        v      = membrane;
        leak   = $signed(regs.leak_value);
        rlevel = $signed(regs.reset_potential);
        alpha  = regs.pos_threshold;
        beta   = regs.neg_threshold;
        n      = regs.threshold_random & regs.threshold_mask;
        rmode  = regs.mode_bits[4:3];

        v = clamp_membrane(v + syn);
        if (regs.mode_bits[1]) begin
            term = (((leak < 0) ? -leak : leak) >= longint'(regs.leak_random)) ?
                   sign_of(leak) : 0;
        end else begin
            term = leak;
        end
        if (regs.mode_bits[0]) begin
            term = term * sign_of(v);
        end
        v = clamp_membrane(v + term);

        r.status = ST_IDLE;
        if (regs.mode_bits[2]) begin
            if (v < -beta) begin
                r.status = ST_NEG;
                v = clamp_membrane(-beta);
            end
        end else if (v < -(beta + n)) begin
            r.status = ST_NEG;
            case (rmode)
                RST_LOAD: v = clamp_membrane(-rlevel);
                RST_SUB:  v = clamp_membrane(v + beta + n);
                RST_KEEP: ;
                RST_ZERO: v = 0;
            endcase
        end

        // firing looks at the potential as the negative check left it
        if (v >= alpha + n) begin
            r.status = ST_FIRE;
            case (rmode)
                RST_LOAD: v = clamp_membrane(rlevel);
                RST_SUB:  v = clamp_membrane(v - (alpha + n));
                RST_KEEP: ;
                RST_ZERO: v = 0;
            endcase
        end

        membrane    = v[POTENTIAL_WIDTH-1:0];
        r.potential = v[OUT_POT_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        soma_result_t got;
        soma_result_t want;
        if (!aresetn) begin
            regs               = '0;
            regs.pos_threshold = 18'd1;
            membrane           = '0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_LEAK_VALUE:       regs.leak_value       = cfg_wdata[8:0];
                    CFG_POS_THRESHOLD:    regs.pos_threshold    = cfg_wdata[17:0];
                    CFG_NEG_THRESHOLD:    regs.neg_threshold    = cfg_wdata[17:0];
                    CFG_THRESHOLD_MASK:   regs.threshold_mask   = cfg_wdata[17:0];
                    CFG_RESET_POTENTIAL:  regs.reset_potential  = cfg_wdata[18:0];
                    CFG_MODE_BITS:        regs.mode_bits        = cfg_wdata[4:0];
                    CFG_LEAK_RANDOM:      regs.leak_random      = cfg_wdata[7:0];
                    CFG_THRESHOLD_RANDOM: regs.threshold_random = cfg_wdata[17:0];
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.potential = m_tdata[OUT_POT_WIDTH-1:0];
                n_seen++;
                if (got.status == ST_FIRE) n_fire++;
                if (got.status == ST_NEG) n_neg++;
                if (expected_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("result %0d with no tick pending: status %0d potential %0d",
                                 n_seen, got.status, got.potential);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.potential !== want.potential) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result %0d: status exp %0d got %0d, %s",
                                     n_seen, want.status, got.status,
                                     $sformatf("potential exp %0d got %0d",
                                               want.potential, got.potential));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(soma_tick(s_tdata[SYN_WIDTH-1:0]));
            end
        end
        outstanding <= expected_results.size();
        mismatches  <= n_bad;
        checked     <= n_seen;
        spikes      <= n_fire;
        neg_resets  <= n_neg;
    end

endmodule

>>> verif/tb_lif_neuron_soma_update.sv
// testbench top for the lif neuron soma update block: reset, register settings, ticks and verdict
module tb_lif_neuron_soma_update;
    import lifsoma_pkg::*;

    localparam int MAX_WAIT    = 18;
    localparam int RAND_PHASES = 16;
    localparam int RAND_TICKS  = 125;
    localparam int STALL_LIMIT = 1000;

    localparam logic [2:0] PLAIN        = 3'b000;
    localparam logic [2:0] LEAK_REV     = 3'b001;
    localparam logic [2:0] LEAK_STOCH   = 3'b010;
    localparam logic [2:0] NEG_SATURATE = 3'b100;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata   = '0;    // synaptic_sum[17:0]
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [23:0]               m_tdata;           // potential_out[19:0]
    logic [1:0]                m_tuser;           // soma_status[1:0]
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr  = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
    logic                      rx_steady = 1'b0;
    bit                        tx_steady;
    int                        outstanding;
    int                        mismatches;
    int                        checked;
    int                        spikes;
    int                        neg_resets;
    int                        ticks_sent;
    int                        settings_used;
    int                        quiet_cycles;
    int                        rx_hold;

    lif_neuron_soma_update dut (.*);
    lif_soma_checker chk (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (m_tvalid && m_tready) begin
            rx_hold = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            m_tready <= (rx_hold == 0);
        end else if (!m_tready) begin
            if (rx_hold == 0) begin
                m_tready <= 1'b1;
            end else begin
                rx_hold = rx_hold - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic lifsoma_cfg_t soma_cfg(input int leak, input int alpha, input int beta,
                                              input int mask, input int rlevel,
                                              input logic [4:0] mode, input int lrand,
                                              input int trand);
        lifsoma_cfg_t c;
        c.leak_value       = leak[8:0];
        c.pos_threshold    = alpha[17:0];
        c.neg_threshold    = beta[17:0];
        c.threshold_mask   = mask[17:0];
        c.reset_potential  = rlevel[18:0];
        c.mode_bits        = mode;
        c.leak_random      = lrand[7:0];
        c.threshold_random = trand[17:0];
        return c;
    endfunction

    task automatic put_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_regs(input lifsoma_cfg_t c);
        put_reg(CFG_LEAK_VALUE, CFG_DATA_WIDTH'(c.leak_value[8:0]));
        put_reg(CFG_POS_THRESHOLD, CFG_DATA_WIDTH'(c.pos_threshold));
        put_reg(CFG_NEG_THRESHOLD, CFG_DATA_WIDTH'(c.neg_threshold));
        put_reg(CFG_THRESHOLD_MASK, CFG_DATA_WIDTH'(c.threshold_mask));
        put_reg(CFG_RESET_POTENTIAL, c.reset_potential[18:0]);
        put_reg(CFG_MODE_BITS, CFG_DATA_WIDTH'(c.mode_bits));
        put_reg(CFG_LEAK_RANDOM, CFG_DATA_WIDTH'(c.leak_random));
        put_reg(CFG_THRESHOLD_RANDOM, CFG_DATA_WIDTH'(c.threshold_random));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic drive_tick(input int syn);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, syn[SYN_WIDTH-1:0]};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    // block is idle once every pending tick has come back
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    initial begin
        lifsoma_cfg_t c;
        int           bound;
        int           sb;
        int           syn;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: idle, fire, negative crossing
        drive_tick(0);
        drive_tick(1);
        drive_tick(-1);

        // deterministic leak with reversal, subtract reset
        wait_drained();
        load_regs(soma_cfg(255, 1000, 1000, 0, 0, {RST_SUB, LEAK_REV}, 0, 0));
        drive_tick(0);
        drive_tick(500);
        drive_tick(-2000);
        drive_tick(1400);

        // stochastic leak taken at magnitude equal to the random value, reset to zero
        wait_drained();
        load_regs(soma_cfg(-200, 10, 10, 0, 0, {RST_ZERO, LEAK_STOCH}, 200, 0));
        drive_tick(0);
        drive_tick(-20);

        // stochastic leak below the random value, keep mode
        wait_drained();
        load_regs(soma_cfg(199, 10, 10, 0, 0, {RST_KEEP, LEAK_STOCH | LEAK_REV}, 200, 0));
        drive_tick(3);
        drive_tick(-30);

        // negative saturate
        wait_drained();
        load_regs(soma_cfg(0, 5, 300, 0, -7, {RST_LOAD, NEG_SATURATE}, 0, 0));
        drive_tick(-1000);

        // both thresholds crossed in one tick, masked random on thresholds
        wait_drained();
        load_regs(soma_cfg(0, 10, 5, 3, -1000, {RST_LOAD, PLAIN}, 0, 2));
        drive_tick(-100);
        drive_tick(1000);

        // potential saturation at both ends with widest thresholds
        wait_drained();
        load_regs(soma_cfg(0, 262143, 262143, 262143, 0, {RST_KEEP, PLAIN}, 255, 262143));
        repeat (5) drive_tick(131071);
        repeat (8) drive_tick(-131072);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            bound = 262143;
            if (ph == 0) begin
                c = soma_cfg(-256, 0, 0, 0, -262144, {RST_LOAD, PLAIN}, 0, 0);
            end else if (ph == 1) begin
                c = soma_cfg(255, 262143, 262143, 262143, 262143,
                             {RST_ZERO, NEG_SATURATE | LEAK_STOCH | LEAK_REV}, 255, 262143);
            end else begin
                bound = (1 << $urandom_range(3, 18)) - 1;
                c = soma_cfg($urandom_range(0, 511), $urandom_range(0, bound),
                             $urandom_range(0, bound),
                             $urandom_range(0, 1) ? $urandom_range(0, 262143)
                                                  : ($urandom_range(0, 262143) & bound),
                             $urandom_range(0, 2 * bound) - bound, 5'($urandom_range(0, 31)),
                             $urandom_range(0, 255), $urandom_range(0, 262143));
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady <= ($urandom_range(0, 3) == 0);
            load_regs(c);
            sb = (bound > 131071) ? 131071 : bound;
            repeat (RAND_TICKS) begin
                if ($urandom_range(0, 7) == 0) begin
                    syn = $urandom_range(0, 262143);
                end else begin
                    syn = $urandom_range(0, 2 * sb) - sb;
                end
                drive_tick(syn);
            end
        end

        wait_drained();
        repeat (3) @(posedge aclk);
        $display("%0d ticks over %0d register settings, %0d results checked",
                 ticks_sent, settings_used, checked);
        $display("%0d spikes and %0d negative threshold crossings observed",
                 spikes, neg_resets);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/lifsoma_pkg.sv
rtl/lifsoma_core.sv
rtl/lif_neuron_soma_update.sv
verif/lif_soma_checker.sv
verif/tb_lif_neuron_soma_update.sv
